/* rtl/slice_pixel_compositor_core_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef SLICE_PIXEL_COMPOSITOR_CORE_ASSERT_SVH
`define SLICE_PIXEL_COMPOSITOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slice pixel compositor port check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slice pixel compositor port check failed");

`endif

/* rtl/spc_pkg.sv */
package spc_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CFG_WINDOW_LOW    = 3'd0;
   localparam logic [2:0] CFG_WINDOW_HIGH   = 3'd1;
   localparam logic [2:0] CFG_BASE_MODE     = 3'd2;
   localparam logic [2:0] CFG_OVERLAY_MODE  = 3'd3;
   localparam logic [2:0] CFG_OVERLAY_ALPHA = 3'd4;
   localparam logic [2:0] CFG_OVERLAY_LOW   = 3'd5;
   localparam logic [2:0] CFG_OVERLAY_HIGH  = 3'd6;
   localparam logic [2:0] CFG_LABEL_ALPHA   = 3'd7;

   // Color map modes.
   localparam logic [2:0] MODE_GRAY    = 3'd0;
   localparam logic [2:0] MODE_HOT     = 3'd1;
   localparam logic [2:0] MODE_COOL    = 3'd2;
   localparam logic [2:0] MODE_VIRIDIS = 3'd3;
   localparam logic [2:0] MODE_OFF     = 3'd4;

   // HSV label colors in Q0.16; the hue step PHI_FRAC is Q0.32.
   localparam longint unsigned ONE16    = 65536;
   localparam longint unsigned SAT      = 45875;
   localparam longint unsigned VAL_LO   = 49152;
   localparam longint unsigned VAL_HI   = 62259;
   localparam longint unsigned PVAL_LO  = (VAL_LO * (ONE16 - SAT)) >> 16;
   localparam longint unsigned PVAL_HI  = (VAL_HI * (ONE16 - SAT)) >> 16;
   localparam logic [31:0]     PHI_FRAC = 32'd2654435769;
   // Reciprocal of seven, exact for 15-bit operands after a shift by 20.
   localparam logic [17:0]     DIV7_MUL = 18'd149797;
   localparam int unsigned     DIV7_SHIFT = 20;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Prepared window operands for the pipelined divider.
   typedef struct packed {
      logic [15:0] num;
      logic [15:0] den;
      logic        zero;
      logic        full;
   } win_type;

   function automatic logic [7:0] sat8(input logic [10:0] x);
      return (x > 11'd255) ? 8'd255 : x[7:0];
   endfunction

   function automatic win_type win_prep(input logic [15:0] x, input logic [15:0] lo,
                                        input logic [15:0] hi);
      logic [16:0] diff;
      logic [16:0] rng;
      win_type     w;
      diff   = {x[15], x} - {lo[15], lo};
      rng    = {hi[15], hi} - {lo[15], lo};
      w.den  = (rng[16] || rng == 17'd0) ? 16'd1 : rng[15:0];
      w.num  = diff[15:0];
      w.zero = diff[16] || diff == 17'd0;
      w.full = !w.zero && (diff[15:0] >= w.den);
      return w;
   endfunction

   function automatic logic [15:0] vir_knot(input logic [1:0] ch, input logic [1:0] seg);
      logic [15:0] k;
      case ({ch, seg})
         4'h0: k = 16'd17498;
         4'h1: k = 16'd8389;
         4'h2: k = 16'd24183;
         4'h3: k = 16'd65077;
         4'h4: k = 16'd328;
         4'h5: k = 16'd37487;
         4'h6: k = 16'd51642;
         4'h7: k = 16'd59376;
         4'h8: k = 16'd21561;
         4'h9: k = 16'd36241;
         4'hA: k = 16'd25690;
         4'hB: k = 16'd9437;
         default: k = 16'd0;
      endcase
      return k;
   endfunction

   function automatic rgb_type label_rgb(input logic [4:0] idx);
      rgb_type c;
      case (idx)
         5'd0:  c = '{8'd31,  8'd119, 8'd180};
         5'd1:  c = '{8'd174, 8'd199, 8'd232};
         5'd2:  c = '{8'd255, 8'd127, 8'd14};
         5'd3:  c = '{8'd255, 8'd187, 8'd120};
         5'd4:  c = '{8'd44,  8'd160, 8'd44};
         5'd5:  c = '{8'd152, 8'd223, 8'd138};
         5'd6:  c = '{8'd214, 8'd39,  8'd40};
         5'd7:  c = '{8'd255, 8'd152, 8'd150};
         5'd8:  c = '{8'd148, 8'd103, 8'd189};
         5'd9:  c = '{8'd197, 8'd176, 8'd213};
         5'd10: c = '{8'd140, 8'd86,  8'd75};
         5'd11: c = '{8'd196, 8'd156, 8'd148};
         5'd12: c = '{8'd227, 8'd119, 8'd194};
         5'd13: c = '{8'd247, 8'd182, 8'd210};
         5'd14: c = '{8'd127, 8'd127, 8'd127};
         5'd15: c = '{8'd199, 8'd199, 8'd199};
         5'd16: c = '{8'd188, 8'd189, 8'd34};
         5'd17: c = '{8'd219, 8'd219, 8'd141};
         5'd18: c = '{8'd23,  8'd190, 8'd207};
         5'd19: c = '{8'd158, 8'd218, 8'd229};
         default: c = '{8'd0, 8'd0, 8'd0};
      endcase
      return c;
   endfunction

endpackage

/* rtl/spc_chan.sv */
// One windowed channel: a four-stage radix-2 divider (four quotient bits per
// stage) followed by two color map stages.
module spc_chan (
   input  logic             clock,
   input  logic [5:0]       ld,        // load enables of pipeline stages 2..7
   input  logic [2:0]       mode,
   input  spc_pkg::win_type win,
   output logic [16:0]      t_out,     // Q1.16 fraction at stage 5
   output spc_pkg::rgb_type rgb        // mapped color at stage 7
);

   logic [15:0]      rem_ff [4];
   logic [15:0]      quo_ff [4];
   spc_pkg::win_type win_ff [4];
   logic [15:0]      rem_in [4];
   logic [15:0]      quo_in [4];
   logic [15:0]      rem_src [4];
   logic [15:0]      quo_src [4];
   spc_pkg::win_type win_src [4];

   function automatic logic [7:0] scale255(input logic [18:0] x);
      logic [26:0] p;
      p = ({8'd0, x} << 8) - {8'd0, x};
      return spc_pkg::sat8(p[26:16]);
   endfunction

   always_comb begin
      rem_src[0] = win.num;
      quo_src[0] = 16'd0;
      win_src[0] = win;
      for (int s = 1; s < 4; s++) begin
         rem_src[s] = rem_ff[s-1];
         quo_src[s] = quo_ff[s-1];
         win_src[s] = win_ff[s-1];
      end
   end

   // The remainder stays below the divisor, so each step is a 17-bit compare.
   always_comb begin
      logic [15:0] r;
      logic [15:0] q;
      logic [16:0] r2;
      for (int s = 0; s < 4; s++) begin
         r = rem_src[s];
         q = quo_src[s];
         for (int b = 0; b < 4; b++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, win_src[s].den}) begin
               r2 = r2 - {1'b0, win_src[s].den};
               q  = {q[14:0], 1'b1};
            end else begin
               q  = {q[14:0], 1'b0};
            end
            r = r2[15:0];
         end
         rem_in[s] = r;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < 4; s++) begin
         if (ld[s]) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            win_ff[s] <= win_src[s];
         end
      end
   end

   assign t_out = win_ff[3].zero ? 17'd0 :
                  win_ff[3].full ? 17'h10000 : {1'b0, quo_ff[3]};

   // First map stage: direct maps and the viridis partial products.
   logic [18:0]      t3;
   logic [1:0]       seg;
   logic [16:0]      u;
   logic [16:0]      u_inv;
   spc_pkg::rgb_type gray_in, hot_in, cool_in;
   logic [32:0]      pa_in [3];
   logic [32:0]      pb_in [3];
   spc_pkg::rgb_type gray_ff, hot_ff, cool_ff;
   logic [32:0]      pa_ff [3];
   logic [32:0]      pb_ff [3];

   always_comb begin
      t3       = {2'b0, t_out} + {1'b0, t_out, 1'b0};
      seg      = (t3[18:16] > 3'd2) ? 2'd2 : t3[17:16];
      u        = 17'(t3 - {1'b0, seg, 16'd0});
      u_inv    = 17'h10000 - u;
      gray_in  = '{scale255({2'b0, t_out}), scale255({2'b0, t_out}),
                   scale255({2'b0, t_out})};
      hot_in.red   = scale255(t3);
      hot_in.green = (t3 > 19'h10000) ? scale255(t3 - 19'h10000) : 8'd0;
      hot_in.blue  = (t3 > 19'h20000) ? scale255(t3 - 19'h20000) : 8'd0;
      cool_in.red   = scale255({2'b0, t_out});
      cool_in.green = scale255({2'b0, 17'h10000 - t_out});
      cool_in.blue  = 8'd255;
      for (int c = 0; c < 3; c++) begin
         pa_in[c] = 33'(spc_pkg::vir_knot(2'(c), seg)) * 33'(u_inv);
         pb_in[c] = 33'(spc_pkg::vir_knot(2'(c), 2'(seg + 2'd1))) * 33'(u);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         gray_ff <= gray_in;
         hot_ff  <= hot_in;
         cool_ff <= cool_in;
         for (int c = 0; c < 3; c++) begin
            pa_ff[c] <= pa_in[c];
            pb_ff[c] <= pb_in[c];
         end
      end
   end

   // Second map stage: viridis sum and scale, then mode select.
   logic [7:0]       vir [3];
   spc_pkg::rgb_type rgb_in;
   spc_pkg::rgb_type rgb_ff;

   always_comb begin
      logic [33:0] mix;
      logic [41:0] sc;
      for (int c = 0; c < 3; c++) begin
         mix    = 34'(pa_ff[c]) + 34'(pb_ff[c]);
         sc     = (42'(mix) << 8) - 42'(mix);
         vir[c] = spc_pkg::sat8({1'b0, sc[41:32]});
      end
      case (mode)
         spc_pkg::MODE_GRAY:    rgb_in = gray_ff;
         spc_pkg::MODE_HOT:     rgb_in = hot_ff;
         spc_pkg::MODE_COOL:    rgb_in = cool_ff;
         spc_pkg::MODE_VIRIDIS: rgb_in = '{vir[0], vir[1], vir[2]};
         default:               rgb_in = '{8'd0, 8'd0, 8'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         rgb_ff <= rgb_in;
      end
   end

   assign rgb = rgb_ff;

endmodule

/* rtl/spc_label.sv */
// Label color: table for the first twenty labels, golden-ratio HSV beyond.
// Four stages: hue and value select, sector and fraction, q and w, select.
module spc_label (
   input  logic             clock,
   input  logic [3:0]       ld,        // load enables of pipeline stages 2..5
   input  logic [14:0]      idx,       // label minus one
   output spc_pkg::rgb_type rgb
);

   logic [14:0]      k;
   logic [32:0]      kd;
   logic [31:0]      h_in, h_ff;
   logic             vsel2_ff, vsel3_ff, vsel4_ff;
   logic             tbl2_ff, tbl3_ff, tbl4_ff;
   logic [4:0]       ti2_ff, ti3_ff, ti4_ff;

   always_comb begin
      k    = idx - 15'd20;
      h_in = 32'({17'd0, k} * spc_pkg::PHI_FRAC);
      kd   = 33'(k) * 33'(spc_pkg::DIV7_MUL);
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         h_ff     <= h_in;
         vsel2_ff <= kd[spc_pkg::DIV7_SHIFT];
         tbl2_ff  <= (idx < 15'd20);
         ti2_ff   <= idx[4:0];
      end
   end

   logic [34:0] h6;
   logic [15:0] f;
   logic [31:0] fs_p;
   logic [32:0] fs2_p;
   logic [2:0]  sect3_ff;
   logic [15:0] fs_ff, fs2_ff;

   always_comb begin
      h6    = ({3'd0, h_ff} << 2) + ({3'd0, h_ff} << 1);
      f     = h6[31:16];
      fs_p  = 32'(f) * 32'(spc_pkg::SAT);
      fs2_p = 33'(17'h10000 - {1'b0, f}) * 33'(spc_pkg::SAT);
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         sect3_ff <= h6[34:32];
         fs_ff    <= fs_p[31:16];
         fs2_ff   <= fs2_p[31:16];
         vsel3_ff <= vsel2_ff;
         tbl3_ff  <= tbl2_ff;
         ti3_ff   <= ti2_ff;
      end
   end

   logic [15:0] v3;
   logic [32:0] q_p, w_p;
   logic [2:0]  sect4_ff;
   logic [15:0] q_ff, w_ff;

   always_comb begin
      v3  = vsel3_ff ? 16'(spc_pkg::VAL_HI) : 16'(spc_pkg::VAL_LO);
      q_p = 33'(v3) * 33'(17'h10000 - {1'b0, fs_ff});
      w_p = 33'(v3) * 33'(17'h10000 - {1'b0, fs2_ff});
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         q_ff     <= q_p[31:16];
         w_ff     <= w_p[31:16];
         sect4_ff <= sect3_ff;
         vsel4_ff <= vsel3_ff;
         tbl4_ff  <= tbl3_ff;
         ti4_ff   <= ti3_ff;
      end
   end

   logic [15:0]      v4, p4;
   logic [15:0]      c [3];
   spc_pkg::rgb_type hsv;
   spc_pkg::rgb_type rgb_ff;

   function automatic logic [7:0] scale_q16(input logic [15:0] x);
      logic [23:0] p;
      p = ({8'd0, x} << 8) - {8'd0, x};
      return spc_pkg::sat8({3'd0, p[23:16]});
   endfunction

   always_comb begin
      v4 = vsel4_ff ? 16'(spc_pkg::VAL_HI) : 16'(spc_pkg::VAL_LO);
      p4 = vsel4_ff ? 16'(spc_pkg::PVAL_HI) : 16'(spc_pkg::PVAL_LO);
      case (sect4_ff)
         3'd0: begin c[0] = v4;   c[1] = w_ff; c[2] = p4;   end
         3'd1: begin c[0] = q_ff; c[1] = v4;   c[2] = p4;   end
         3'd2: begin c[0] = p4;   c[1] = v4;   c[2] = w_ff; end
         3'd3: begin c[0] = p4;   c[1] = q_ff; c[2] = v4;   end
         3'd4: begin c[0] = w_ff; c[1] = p4;   c[2] = v4;   end
         default: begin c[0] = v4; c[1] = p4;  c[2] = q_ff; end
      endcase
      hsv = '{scale_q16(c[0]), scale_q16(c[1]), scale_q16(c[2])};
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         rgb_ff <= tbl4_ff ? spc_pkg::label_rgb(ti4_ff) : hsv;
      end
   end

   assign rgb = rgb_ff;

endmodule

/* rtl/slice_pixel_compositor_core.sv */
// Channel  Direction  Payload (lowest bits first)
// req_     in         base_intensity, overlay_value, label_value (16 bit each)
// rsp_     out        red, green, blue (8 bit each)
// csr_     in         write enable, 3-bit register index, 16-bit data
//
// Nine register stages; one pixel per clock when rsp_tready stays high. The divider
// (four stages, four quotient bits each) sets the depth.
// Synchronous active-high reset clears the valid bits and loads the configuration
// defaults; data registers are qualified by the valid bits and are not cleared.
// A stage holds when the stage after it is full and cannot move; bubbles close up.
module slice_pixel_compositor_core #(
   parameter int LABEL_LIMIT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // base_intensity, overlay_value, label_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red, green, blue
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [16:0] LIM17 = 17'(LABEL_LIMIT);

   // Configuration registers.
   logic [15:0] window_low_ff, window_high_ff, overlay_low_ff, overlay_high_ff;
   logic [2:0]  base_mode_ff, overlay_mode_ff;
   logic [7:0]  overlay_alpha_ff, label_alpha_ff;
   logic [14:0] la_y;
   logic [15:0] la_w_in, la_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff    <= 16'd0;
         window_high_ff   <= 16'd4095;
         base_mode_ff     <= spc_pkg::MODE_GRAY;
         overlay_mode_ff  <= spc_pkg::MODE_OFF;
         overlay_alpha_ff <= 8'd128;
         overlay_low_ff   <= 16'd0;
         overlay_high_ff  <= 16'd4095;
         label_alpha_ff   <= 8'd255;
      end else if (csr_we) begin
         case (csr_index)
            spc_pkg::CFG_WINDOW_LOW:    window_low_ff    <= csr_wdata;
            spc_pkg::CFG_WINDOW_HIGH:   window_high_ff   <= csr_wdata;
            spc_pkg::CFG_BASE_MODE:     base_mode_ff     <= csr_wdata[2:0];
            spc_pkg::CFG_OVERLAY_MODE:  overlay_mode_ff  <= csr_wdata[2:0];
            spc_pkg::CFG_OVERLAY_ALPHA: overlay_alpha_ff <= csr_wdata[7:0];
            spc_pkg::CFG_OVERLAY_LOW:   overlay_low_ff   <= csr_wdata;
            spc_pkg::CFG_OVERLAY_HIGH:  overlay_high_ff  <= csr_wdata;
            spc_pkg::CFG_LABEL_ALPHA:   label_alpha_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Label weight 115 * alpha * 256 / 255, written as y + y / 255 with y = 115 * alpha.
   always_comb begin
      la_y    = 15'(label_alpha_ff * 15'd115);
      la_w_in = 16'(la_y) + 16'((16'(la_y) + 16'(la_y >> 8) + 16'd1) >> 8);
   end

   always_ff @(posedge clock) begin
      la_w_ff <= la_w_in;
   end

   // Pipeline control.
   logic [9:1]  v_ff;
   logic [9:1]  v_in;
   logic [10:1] ld;

   always_comb begin
      ld[10] = rsp_tready;
      for (int i = 9; i >= 1; i--) begin
         ld[i] = !v_ff[i] || ld[i+1];
      end
      v_in[1] = ld[1] ? req_tvalid : v_ff[1];
      for (int i = 2; i <= 9; i++) begin
         v_in[i] = ld[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = ld[1];
   assign rsp_tvalid = v_ff[9];

   // Stage 1: window operands and label decode.
   logic [15:0]      lab;
   logic             lab_on1;
   spc_pkg::win_type owin_in;
   spc_pkg::win_type bwin_ff, owin_ff;
   logic [14:0]      lab_idx_ff;
   logic [8:1]       lab_on_ff;
   logic [7:1]       ov_on_ff;

   assign lab     = req_tdata[47:32];
   assign lab_on1 = !lab[15] && lab != 16'd0 && ({1'b0, lab} < LIM17);
   assign owin_in = spc_pkg::win_prep(req_tdata[31:16], overlay_low_ff, overlay_high_ff);

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         bwin_ff      <= spc_pkg::win_prep(req_tdata[15:0], window_low_ff, window_high_ff);
         owin_ff      <= owin_in;
         lab_idx_ff   <= 15'(lab - 16'd1);
         lab_on_ff[1] <= lab_on1;
         ov_on_ff[1]  <= !owin_in.zero;
      end
      for (int i = 2; i <= 8; i++) begin
         if (ld[i]) begin
            lab_on_ff[i] <= lab_on_ff[i-1];
         end
      end
      for (int i = 2; i <= 7; i++) begin
         if (ld[i]) begin
            ov_on_ff[i] <= ov_on_ff[i-1];
         end
      end
   end

   // Stages 2 to 7: divide and map both layers; label color in parallel.
   logic [16:0]      base_t, ov_t;
   spc_pkg::rgb_type base_rgb, ov_rgb, lab_rgb;

   spc_chan u_base (
      .clock (clock),
      .ld    (ld[7:2]),
      .mode  (base_mode_ff),
      .win   (bwin_ff),
      .t_out (base_t),
      .rgb   (base_rgb)
   );

   spc_chan u_overlay (
      .clock (clock),
      .ld    (ld[7:2]),
      .mode  (overlay_mode_ff),
      .win   (owin_ff),
      .t_out (ov_t),
      .rgb   (ov_rgb)
   );

   spc_label u_label (
      .clock (clock),
      .ld    (ld[5:2]),
      .idx   (lab_idx_ff),
      .rgb   (lab_rgb)
   );

   // The base t is not needed past the divider.
   logic [23:0]      wgt6_ff, wgt7_ff;
   spc_pkg::rgb_type lab6_ff, lab7_ff, lab8_ff;

   always_ff @(posedge clock) begin
      if (ld[6]) begin
         wgt6_ff <= 24'(overlay_alpha_ff * ov_t);
         lab6_ff <= lab_rgb;
      end
      if (ld[7]) begin
         wgt7_ff <= wgt6_ff;
         lab7_ff <= lab6_ff;
      end
      if (ld[8]) begin
         lab8_ff <= lab7_ff;
      end
   end

   // Stage 8: overlay blend.
   function automatic logic [7:0] blend24(input logic [7:0] b, input logic [7:0] o,
                                          input logic [23:0] w);
      logic [33:0] s;
      s = 34'(b) * 34'(25'h1000000 - {1'b0, w}) + 34'(o) * 34'(w);
      return spc_pkg::sat8({1'b0, s[33:24]});
   endfunction

   function automatic logic [7:0] blend16(input logic [7:0] b, input logic [7:0] o,
                                          input logic [15:0] a);
      logic [25:0] s;
      s = 26'(b) * 26'(17'h10000 - {1'b0, a}) + 26'(o) * 26'(a);
      return spc_pkg::sat8({1'b0, s[25:16]});
   endfunction

   logic             ov_use;
   spc_pkg::rgb_type pix8_ff, out_ff;
   logic [7:0]       mixed [3];

   assign ov_use = ov_on_ff[7] && (overlay_mode_ff < spc_pkg::MODE_OFF);

   always_comb begin
      mixed[0] = blend24(base_rgb.red,   ov_rgb.red,   wgt7_ff);
      mixed[1] = blend24(base_rgb.green, ov_rgb.green, wgt7_ff);
      mixed[2] = blend24(base_rgb.blue,  ov_rgb.blue,  wgt7_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[8]) begin
         pix8_ff <= ov_use ? '{mixed[0], mixed[1], mixed[2]} : base_rgb;
      end
      // Stage 9: label blend into the output register.
      if (ld[9]) begin
         out_ff <= lab_on_ff[8] ?
                   '{blend16(pix8_ff.red,   lab8_ff.red,   la_w_ff),
                     blend16(pix8_ff.green, lab8_ff.green, la_w_ff),
                     blend16(pix8_ff.blue,  lab8_ff.blue,  la_w_ff)} : pix8_ff;
      end
   end

   assign rsp_tdata = {out_ff.blue, out_ff.green, out_ff.red};

endmodule

/* rtl/spc_checker.sv */
`include "slice_pixel_compositor_core_assert.svh"

module spc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A waiting result stays offered with the same pixel.
   `SPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `SPC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // When the output register can move, every stage can move, so input is taken.
   `SPC_ASSERT_NOW(a_ready_when_drain, clock, reset, !rsp_tvalid || rsp_tready, req_tready)

   // No pixel appears right after reset.
   `SPC_ASSERT_NOW(a_empty_after_reset, clock, 1'b0, $past(reset) && !reset, !rsp_tvalid)

endmodule

bind slice_pixel_compositor_core spc_checker u_spc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/tb.sv */
module tb;

   localparam int LIMIT = 256;
   localparam int ITEMS = 1100;
   localparam longint unsigned Q16 = 65536;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // base_intensity, overlay_value, label_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // red, green, blue
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   bit          calm = 1'b0;     // no idling on either side while set

   always #1 clock = ~clock;

   slice_pixel_compositor_core #(.LABEL_LIMIT(LIMIT)) dut (.*);

   // Register copies used by the pixel predictor.
   logic signed [15:0] win_lo, win_hi, ovl_lo, ovl_hi;
   logic [2:0]         base_md, ovl_md;
   logic [7:0]         ovl_alpha, lbl_alpha;

   function automatic longint unsigned clip255(longint unsigned v);
      return (v > 255) ? 255 : v;
   endfunction

   function automatic longint unsigned window_frac(logic signed [15:0] x,
         logic signed [15:0] lo, logic signed [15:0] hi);
      int               rng, num;
      longint unsigned  q;
      rng = int'(hi) - int'(lo);
      num = int'(x) - int'(lo);
      if (rng < 1) rng = 1;
      if (num <= 0) return 0;
      q = (longint'(num) << 16) / rng;
      return (q > Q16) ? Q16 : q;
   endfunction

   function automatic spc_pkg::rgb_type map_color(logic [2:0] md, longint unsigned t);
      longint unsigned t3, u, mix, knot [3][4];
      longint unsigned seg;
      spc_pkg::rgb_type c;
      t3 = t * 3;
      knot = '{'{17498, 8389, 24183, 65077}, '{328, 37487, 51642, 59376},
               '{21561, 36241, 25690, 9437}};
      case (md)
         spc_pkg::MODE_HOT: begin
            c.red   = 8'(clip255((t3 * 255) >> 16));
            c.green = (t3 > Q16) ? 8'(clip255(((t3 - Q16) * 255) >> 16)) : 8'd0;
            c.blue  = (t3 > 2 * Q16) ? 8'(clip255(((t3 - 2 * Q16) * 255) >> 16)) : 8'd0;
         end
         spc_pkg::MODE_COOL: begin
            c.red   = 8'((t * 255) >> 16);
            c.green = 8'(((Q16 - t) * 255) >> 16);
            c.blue  = 8'd255;
         end
         spc_pkg::MODE_VIRIDIS: begin
            seg = t3 >> 16;
            if (seg > 2) seg = 2;
            u = t3 - seg * Q16;
            mix = knot[0][seg] * (Q16 - u) + knot[0][seg + 1] * u;
            c.red = 8'(clip255((mix * 255) >> 32));
            mix = knot[1][seg] * (Q16 - u) + knot[1][seg + 1] * u;
            c.green = 8'(clip255((mix * 255) >> 32));
            mix = knot[2][seg] * (Q16 - u) + knot[2][seg + 1] * u;
            c.blue = 8'(clip255((mix * 255) >> 32));
         end
         default: begin
            c.red = 8'((t * 255) >> 16);
            c.green = c.red;
            c.blue = c.red;
         end
      endcase
      return c;
   endfunction

   function automatic spc_pkg::rgb_type label_color(int lbl);
      longint unsigned k, h, h6, sect, f, v, p, q, w, c0, c1, c2;
      spc_pkg::rgb_type c;
      if (lbl <= 20) return spc_pkg::label_rgb(5'(lbl - 1));
      k = lbl - 21;
      h = (k * 64'd2654435769) & 64'hFFFF_FFFF;
      h6 = h * 6;
      sect = h6 >> 32;
      f = (h6 & 64'hFFFF_FFFF) >> 16;
      v = ((k / 7) % 2 == 0) ? 49152 : 62259;
      p = (v * (Q16 - 45875)) >> 16;
      q = (v * (Q16 - ((f * 45875) >> 16))) >> 16;
      w = (v * (Q16 - (((Q16 - f) * 45875) >> 16))) >> 16;
      case (sect)
         0: begin c0 = v; c1 = w; c2 = p; end
         1: begin c0 = q; c1 = v; c2 = p; end
         2: begin c0 = p; c1 = v; c2 = w; end
         3: begin c0 = p; c1 = q; c2 = v; end
         4: begin c0 = w; c1 = p; c2 = v; end
         default: begin c0 = v; c1 = p; c2 = q; end
      endcase
      c.red = 8'(clip255((c0 * 255) >> 16));
      c.green = 8'(clip255((c1 * 255) >> 16));
      c.blue = 8'(clip255((c2 * 255) >> 16));
      return c;
   endfunction

   function automatic spc_pkg::rgb_type composite_pixel(logic [47:0] px);
      logic signed [15:0] b, o, l;
      longint unsigned    t, wgt, a, pix [3], col [3];
      spc_pkg::rgb_type   c;
      b = px[15:0];
      o = px[31:16];
      l = px[47:32];
      pix = '{0, 0, 0};
      if (base_md < spc_pkg::MODE_OFF) begin
         c = map_color(base_md, window_frac(b, win_lo, win_hi));
         pix = '{c.red, c.green, c.blue};
      end
      if (ovl_md < spc_pkg::MODE_OFF && o > ovl_lo) begin
         t = window_frac(o, ovl_lo, ovl_hi);
         wgt = ovl_alpha * t;
         c = map_color(ovl_md, t);
         col = '{c.red, c.green, c.blue};
         for (int i = 0; i < 3; i++)
            pix[i] = clip255((pix[i] * ((64'd1 << 24) - wgt) + col[i] * wgt) >> 24);
      end
      if (l > 0 && int'(l) < LIMIT) begin
         a = (115 * longint'(lbl_alpha) * 256) / 255;
         c = label_color(int'(l));
         col = '{c.red, c.green, c.blue};
         for (int i = 0; i < 3; i++)
            pix[i] = clip255((pix[i] * (Q16 - a) + col[i] * a) >> 16);
      end
      return {8'(pix[0]), 8'(pix[1]), 8'(pix[2])};
   endfunction

   class pixel_scoreboard;
      spc_pkg::rgb_type pending [$];
      int               mismatches = 0;

      function void note_pixel(spc_pkg::rgb_type c);
         pending = {pending, c};
      endfunction

      function void check_pixel(logic [23:0] got);
         spc_pkg::rgb_type want;
         spc_pkg::rgb_type act;
         act = {got[7:0], got[15:8], got[23:16]};
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pixel %h", got);
            return;
         end
         want = pending.pop_front();
         if (want.red != act.red || want.green != act.green || want.blue != act.blue) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                        want.red, want.green, want.blue, act.red, act.green, act.blue);
         end
      endfunction
   endclass

   pixel_scoreboard board = new();

   // rsp_tdata packs red in the lowest byte.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_pixel(rsp_tdata);
      if (!reset && req_tvalid && req_tready) board.note_pixel(composite_pixel(req_tdata));
   end

   always @(negedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
   end

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         spc_pkg::CFG_WINDOW_LOW:    win_lo = val;
         spc_pkg::CFG_WINDOW_HIGH:   win_hi = val;
         spc_pkg::CFG_BASE_MODE:     base_md = val[2:0];
         spc_pkg::CFG_OVERLAY_MODE:  ovl_md = val[2:0];
         spc_pkg::CFG_OVERLAY_ALPHA: ovl_alpha = val[7:0];
         spc_pkg::CFG_OVERLAY_LOW:   ovl_lo = val;
         spc_pkg::CFG_OVERLAY_HIGH:  ovl_hi = val;
         spc_pkg::CFG_LABEL_ALPHA:   lbl_alpha = val[7:0];
         default: ;
      endcase
   endtask

   task automatic send_pixel(logic [15:0] b, logic [15:0] o, logic [15:0] l);
      while (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {l, o, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_value(logic signed [15:0] lo, logic signed [15:0] hi);
      int r;
      r = $urandom_range(9);
      if (r == 0) return 16'($urandom);
      if (r == 1) return lo;
      if (r == 2) return hi;
      return 16'(int'(lo) - 40 + $urandom_range(int'(hi) - int'(lo) + 80));
   endfunction

   task automatic random_config;
      logic [15:0] a, b;
      a = 16'($urandom_range(2) == 0 ? $urandom : $urandom_range(4000));
      b = 16'($urandom_range(5) == 0 ? $urandom : a + $urandom_range(5000));
      write_reg(spc_pkg::CFG_WINDOW_LOW, a);
      write_reg(spc_pkg::CFG_WINDOW_HIGH, b);
      write_reg(spc_pkg::CFG_BASE_MODE, 16'($urandom_range(7)));
      write_reg(spc_pkg::CFG_OVERLAY_MODE, 16'($urandom_range(7)));
      write_reg(spc_pkg::CFG_OVERLAY_ALPHA, 16'($urandom_range(255)));
      a = 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(2000));
      b = 16'($urandom_range(5) == 0 ? $urandom : a + $urandom_range(3000));
      write_reg(spc_pkg::CFG_OVERLAY_LOW, a);
      write_reg(spc_pkg::CFG_OVERLAY_HIGH, b);
      write_reg(spc_pkg::CFG_LABEL_ALPHA,
                16'($urandom_range(3) == 0 ? 255 : $urandom_range(255)));
   endtask

   task automatic random_label(output logic [15:0] l);
      int r;
      r = $urandom_range(9);
      if (r < 3) l = 0;
      else if (r < 5) l = 16'($urandom_range(1, 20));
      else if (r < 8) l = 16'($urandom_range(21, LIMIT + 2));
      else l = 16'($urandom);
   endtask

   initial begin
      logic [15:0] l;
      win_lo = 0; win_hi = 4095; base_md = spc_pkg::MODE_GRAY; ovl_md = spc_pkg::MODE_OFF;
      ovl_alpha = 128; ovl_lo = 0; ovl_hi = 4095; lbl_alpha = 255;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pixels on reset settings: window extremes and label cases.
      send_pixel(16'h8000, 16'h0, 16'h0);
      send_pixel(16'h7FFF, 16'h7FFF, 16'h0001);
      send_pixel(16'd0, 16'h8000, 16'd20);
      send_pixel(16'd2048, 16'd0, 16'd21);
      send_pixel(16'd4095, 16'd0, 16'hFFFF);
      send_pixel(16'd100, 16'd0, 16'(LIMIT - 1));
      send_pixel(16'd100, 16'd0, 16'(LIMIT));
      drain();
      // Every overlay map with extreme alpha; zero-width base window.
      write_reg(spc_pkg::CFG_WINDOW_LOW, 16'd500);
      write_reg(spc_pkg::CFG_WINDOW_HIGH, 16'd500);
      write_reg(spc_pkg::CFG_OVERLAY_ALPHA, 16'd255);
      write_reg(spc_pkg::CFG_LABEL_ALPHA, 16'd0);
      for (int m = 0; m < 8; m++) begin
         write_reg(spc_pkg::CFG_BASE_MODE, 16'(m));
         write_reg(spc_pkg::CFG_OVERLAY_MODE, 16'(m));
         send_pixel(16'd500, 16'd0, 16'd3);
         send_pixel(16'd501, 16'd2000, 16'd40);
         send_pixel(16'h7FFF, 16'h7FFF, 16'd0);
         drain();
      end
      write_reg(spc_pkg::CFG_OVERLAY_LOW, 16'h8000);
      write_reg(spc_pkg::CFG_OVERLAY_HIGH, 16'h7FFF);
      write_reg(spc_pkg::CFG_OVERLAY_ALPHA, 16'd0);
      send_pixel(16'd0, 16'h8001, 16'd5);
      drain();

      for (int n = 0; n < ITEMS; n++) begin
         if (n % 100 == 0) begin
            drain();
            random_config();
            calm = (n == 300);
         end
         random_label(l);
         send_pixel(pick_value(win_lo, win_hi), pick_value(ovl_lo, ovl_hi), l);
      end
      drain();
      if (board.mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
